@@ src/led_matrix_pwm_scan_assert.svh @@
// assertion macros for the checker of this block
`ifndef LED_MATRIX_PWM_SCAN_ASSERT_SVH
`define LED_MATRIX_PWM_SCAN_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define LMPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define LMPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lmps_pkg.sv @@
package lmps_pkg;

    localparam int PANEL_WIDTH  = 24;
    localparam int PANEL_HEIGHT = 16;
    localparam int SHIFT_BYTES  = 13;
    localparam int STORE_DEPTH  = PANEL_WIDTH * PANEL_HEIGHT / 2;
    localparam int STORE_AW     = 8;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] OVL_OR   = 2'd0;
    localparam logic [1:0] OVL_NAND = 2'd1;
    localparam logic [1:0] OVL_XOR  = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_SHIFT = 1'b1;

    localparam logic [2:0] ROW_LAST  = 3'd7;
    localparam logic [3:0] DUTY_LAST = 4'd8;
    localparam logic [3:0] BYTE_LAST_PAIR = 4'(SHIFT_BYTES - 2);

    localparam logic [3:0] BRIGHT [4] = '{4'd0, 4'd3, 4'd5, 4'd8};

    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wr_data;
    } t_store_req;

    typedef struct packed {
        logic load;
        logic acc;
        logic sel_b;
    } t_pat_ctrl;

    function automatic logic lit(logic [1:0] level, logic [3:0] duty);
        return BRIGHT[level] > duty;
    endfunction

    // store byte address of one read of a tick: column {grp, ~row}, upper half on first pairs
    function automatic logic [STORE_AW-1:0] tick_addr(logic [3:0] byte_idx, logic [2:0] row,
                                                     logic sel_b);
        logic [2:0] pair;
        logic [2:0] pm3;
        logic       hi;
        logic [1:0] grp;
        pair = byte_idx[3:1];
        pm3  = pair - 3'd3;
        hi   = pair < 3'd3;
        grp  = hi ? pair[1:0] : pm3[1:0];
        return {grp, ~row, hi, sel_b, ~byte_idx[0]};
    endfunction

endpackage

@@ src/lmps_store.sv @@
module lmps_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lmps_pkg::t_store_req                i_req,
    output logic [7:0]                          o_rd_data
);

    logic [7:0] r_mem [lmps_pkg::STORE_DEPTH];
    logic [lmps_pkg::STORE_DEPTH-1:0] r_vld;
    logic [7:0] r_rd_data;
    logic       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.addr];
        end
    end

    // never-written entries read as the cleared value
    assign o_rd_data = r_rd_vld ? r_rd_data : 8'h00;

endmodule

@@ src/lmps_pattern.sv @@
module lmps_pattern (
    input  logic                  i_clk,
    input  lmps_pkg::t_pat_ctrl   i_ctrl,
    input  logic [7:0]            i_data,
    input  logic [3:0]            i_duty,
    output logic [7:0]            o_byte
);

    logic [7:0] pat_a;
    logic [7:0] pat_b;
    logic [7:0] pat;
    logic [7:0] r_acc;
    logic [7:0] n_acc;

    always_comb begin
        pat_a = '0;
        pat_a[0] = lmps_pkg::lit(i_data[7:6], i_duty);
        pat_a[1] = lmps_pkg::lit(i_data[5:4], i_duty);
        pat_a[6] = lmps_pkg::lit(i_data[3:2], i_duty);
        pat_a[7] = lmps_pkg::lit(i_data[1:0], i_duty);
        pat_b = '0;
        pat_b[2] = lmps_pkg::lit(i_data[5:4], i_duty);
        pat_b[3] = lmps_pkg::lit(i_data[7:6], i_duty);
        pat_b[4] = lmps_pkg::lit(i_data[1:0], i_duty);
        pat_b[5] = lmps_pkg::lit(i_data[3:2], i_duty);
        pat = i_ctrl.sel_b ? pat_b : pat_a;
        n_acc = r_acc;
        if (i_ctrl.load) begin
            n_acc = pat;
        end else if (i_ctrl.acc) begin
            n_acc = r_acc | pat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_byte = r_acc;

endmodule

@@ src/led_matrix_pwm_scan.sv @@
// Frame store and PWM row scanner for a 24 x 16 red/green LED matrix, 4-bit pixels, two per
// store byte. One word in at a time: a write reads, merges and writes back, a read fetches and
// then waits on the output, and a scan tick sends 12 panel bytes, each of which needs 2 reads
// of the single store port and 2 passes through the one brightness compare unit, then the row
// select byte. Output back-pressure stalls reads and ticks. The block is not ready while a word
// is in work. The store starts all zero at reset.
module led_matrix_pwm_scan (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // col[5:0], row_sel[10:6], pixel_value[14:11], overlay_mode[16:15]
    input  logic [1:0]  i_s_axis_tuser,  // action[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // out_byte[7:0]
    output logic [0:0]  o_m_axis_tuser,  // kind[0]
    output logic        o_m_axis_tlast
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_MERGE = 4'd2;
    localparam logic [3:0] S_RDOUT = 4'd3;
    localparam logic [3:0] S_TA    = 4'd4;
    localparam logic [3:0] S_TB    = 4'd5;
    localparam logic [3:0] S_TC    = 4'd6;
    localparam logic [3:0] S_TE    = 4'd7;
    localparam logic [3:0] S_TROW  = 4'd8;

    logic [3:0] r_state, n_state;
    logic [5:0] r_col, n_col;
    logic [4:0] r_row, n_row;
    logic [3:0] r_val, n_val;
    logic [1:0] r_mode, n_mode;
    logic       r_oor, n_oor;
    logic       r_rd, n_rd;
    logic [3:0] r_byte, n_byte;
    logic [2:0] r_scan_row, n_scan_row;
    logic [3:0] r_duty, n_duty;
    logic       r_m_valid, n_m_valid;
    logic [7:0] r_m_data, n_m_data;
    logic       r_m_kind, n_m_kind;
    logic       r_m_last, n_m_last;

    logic                 accept;
    logic                 slot_free;
    logic                 in_range;
    logic [5:0]           in_col;
    logic [4:0]           in_row;
    logic [1:0]           in_act;
    logic [7:0]           rd_data;
    logic [7:0]           pat_byte;
    logic [7:0]           wr_bits;
    logic [7:0]           merged;
    logic [lmps_pkg::STORE_AW-1:0] pix_addr;
    lmps_pkg::t_store_req store_req;
    lmps_pkg::t_pat_ctrl  pat_ctrl;

    assign in_col   = i_s_axis_tdata[5:0];
    assign in_row   = i_s_axis_tdata[10:6];
    assign in_act   = i_s_axis_tuser;
    assign in_range = (in_col < 6'(lmps_pkg::PANEL_WIDTH))
                   && (in_row < 5'(lmps_pkg::PANEL_HEIGHT));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free       = !r_m_valid || i_m_axis_tready;
    assign pix_addr        = {r_col[4:0], r_row[3:1]};
    assign wr_bits         = r_row[0] ? {r_val, 4'h0} : {4'h0, r_val};

    always_comb begin
        case (r_mode)
            lmps_pkg::OVL_OR:   merged = rd_data | wr_bits;
            lmps_pkg::OVL_NAND: merged = rd_data & ~wr_bits;
            lmps_pkg::OVL_XOR:  merged = rd_data ^ wr_bits;
            default:            merged = rd_data;
        endcase
    end

    always_comb begin
        store_req.wr_en   = (r_state == S_MERGE);
        store_req.wr_data = merged;
        case (r_state)
            S_TA:    store_req.addr = lmps_pkg::tick_addr(r_byte, r_scan_row, 1'b0);
            S_TB:    store_req.addr = lmps_pkg::tick_addr(r_byte, r_scan_row, 1'b1);
            default: store_req.addr = pix_addr;
        endcase
        pat_ctrl.load  = (r_state == S_TB);
        pat_ctrl.acc   = (r_state == S_TC);
        pat_ctrl.sel_b = (r_state == S_TC);
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_val      = r_val;
        n_mode     = r_mode;
        n_oor      = r_oor;
        n_rd       = r_rd;
        n_byte     = r_byte;
        n_scan_row = r_scan_row;
        n_duty     = r_duty;
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;
        n_m_kind   = r_m_kind;
        n_m_last   = r_m_last;
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_col  = in_col;
                    n_row  = in_row;
                    n_val  = i_s_axis_tdata[14:11];
                    n_mode = i_s_axis_tdata[16:15];
                    n_oor  = !in_range;
                    n_rd   = (in_act == lmps_pkg::ACT_READ);
                    n_byte = '0;
                    case (in_act)
                        lmps_pkg::ACT_WRITE: n_state = in_range ? S_FETCH : S_IDLE;
                        lmps_pkg::ACT_READ:  n_state = S_FETCH;
                        lmps_pkg::ACT_TICK:  n_state = S_TA;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH: begin
                n_state = r_rd ? S_RDOUT : S_MERGE;
            end
            S_MERGE: begin
                n_state = S_IDLE;
            end
            S_RDOUT: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = lmps_pkg::KIND_PIXEL;
                    n_m_last  = 1'b1;
                    if (r_oor) begin
                        n_m_data = 8'h00;
                    end else begin
                        n_m_data = r_row[0] ? {4'h0, rd_data[7:4]} : {4'h0, rd_data[3:0]};
                    end
                    n_state = S_IDLE;
                end
            end
            S_TA: n_state = S_TB;
            S_TB: n_state = S_TC;
            S_TC: n_state = S_TE;
            S_TE: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = lmps_pkg::KIND_SHIFT;
                    n_m_last  = 1'b0;
                    n_m_data  = pat_byte;
                    if (r_byte == lmps_pkg::BYTE_LAST_PAIR) begin
                        n_state = S_TROW;
                    end else begin
                        n_byte  = r_byte + 4'd1;
                        n_state = S_TA;
                    end
                end
            end
            S_TROW: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = lmps_pkg::KIND_SHIFT;
                    n_m_last  = 1'b1;
                    n_m_data  = ~(8'h01 << r_scan_row);
                    if (r_scan_row == lmps_pkg::ROW_LAST) begin
                        n_scan_row = '0;
                        n_duty     = (r_duty == lmps_pkg::DUTY_LAST) ? 4'd0 : r_duty + 4'd1;
                    end else begin
                        n_scan_row = r_scan_row + 3'd1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_byte     <= '0;
            r_scan_row <= '0;
            r_duty     <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_byte     <= n_byte;
            r_scan_row <= n_scan_row;
            r_duty     <= n_duty;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_row    <= n_row;
        r_val    <= n_val;
        r_mode   <= n_mode;
        r_oor    <= n_oor;
        r_rd     <= n_rd;
        r_m_data <= n_m_data;
        r_m_kind <= n_m_kind;
        r_m_last <= n_m_last;
    end

    lmps_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    lmps_pattern u_pattern (
        .i_clk  (i_clk),
        .i_ctrl (pat_ctrl),
        .i_data (rd_data),
        .i_duty (r_duty),
        .o_byte (pat_byte)
    );

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = r_m_data;
    assign o_m_axis_tuser[0] = r_m_kind;
    assign o_m_axis_tlast    = r_m_last;

endmodule

@@ src/lmps_checker.sv @@
`include "led_matrix_pwm_scan_assert.svh"

module lmps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       i_s_tready,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata,
    input logic [0:0] i_m_tuser,
    input logic       i_m_tlast
);

    `LMPS_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast), "output word changed while stalled")
    `LMPS_ASSERT_NOW(a_pixel_word, i_m_tvalid && i_m_tuser[0] == lmps_pkg::KIND_PIXEL, i_m_tlast && i_m_tdata[7:4] == 4'h0, "bad pixel read word")
    `LMPS_ASSERT_NOW(a_row_select, i_m_tvalid && i_m_tuser[0] == lmps_pkg::KIND_SHIFT && i_m_tlast, $countones(i_m_tdata) == 7, "row select not one-cold")
    `LMPS_ASSERT_NOW(a_busy_in_tick, i_m_tvalid && i_m_tuser[0] == lmps_pkg::KIND_SHIFT && !i_m_tlast, !i_s_tready, "input taken during a tick")

endmodule

bind led_matrix_pwm_scan lmps_checker u_lmps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tlast  (o_m_axis_tlast)
);

@@ test/led_matrix_checker.sv @@
module led_matrix_checker
    import lmps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,   // col[5:0], row_sel[10:6], pixel_value[14:11], overlay_mode[16:15]
    input  logic [1:0]  i_in_user,   // action[1:0]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,  // out_byte[7:0]
    input  logic        i_out_kind,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } out_word_t;

    out_word_t  expected_words[$];
    out_word_t  got_word;
    out_word_t  want_word;
    logic [7:0] frame_mem [STORE_DEPTH];
    logic [2:0] scan_row;
    logic [3:0] duty;
    int         fails = 0;
    int         checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic glows(logic [1:0] lv);
        case (lv)
            2'd0:    return 1'b0;
            2'd1:    return duty < 4'd3;
            2'd2:    return duty < 4'd5;
            default: return duty < 4'd8;
        endcase
    endfunction

    // panel bits taken from the first two store bytes of a column group
    function automatic logic [7:0] bits_from_near(logic [7:0] v);
        return {glows(v[1:0]), glows(v[3:2]), 4'b0, glows(v[5:4]), glows(v[7:6])};
    endfunction

    // panel bits taken from the last two store bytes of a column group
    function automatic logic [7:0] bits_from_far(logic [7:0] v);
        return {2'b0, glows(v[3:2]), glows(v[1:0]), glows(v[7:6]), glows(v[5:4]), 2'b0};
    endfunction

    task automatic queue_word(input logic kind, input logic [7:0] data, input logic last);
        out_word_t w;
        w.kind = kind;
        w.data = data;
        w.last = last;
        expected_words.push_back(w);
    endtask

    task automatic predict_tick();
        int         p;
        int         addr;
        logic [7:0] b0, b1, b2, b3;
        for (p = 0; p < 6; p++) begin
            addr = (7 - int'(scan_row) + 8 * (p % 3)) * 8 + ((p < 3) ? 4 : 0);
            b0 = frame_mem[addr];
            b1 = frame_mem[addr + 1];
            b2 = frame_mem[addr + 2];
            b3 = frame_mem[addr + 3];
            queue_word(KIND_SHIFT, bits_from_near(b1) | bits_from_far(b3), 1'b0);
            queue_word(KIND_SHIFT, bits_from_near(b0) | bits_from_far(b2), 1'b0);
        end
        queue_word(KIND_SHIFT, ~(8'd1 << scan_row), 1'b1);
        if (scan_row == 3'd7) begin
            scan_row = 3'd0;
            duty = (duty == 4'd8) ? 4'd0 : duty + 4'd1;
        end else begin
            scan_row = scan_row + 3'd1;
        end
    endtask

    task automatic predict_word(input logic [1:0] act, input logic [23:0] d);
        logic [5:0] col;
        logic [4:0] row;
        logic [3:0] val;
        logic [1:0] mode;
        logic [7:0] merge;
        logic [3:0] nib;
        int         idx;
        bit         in_range;
        col      = d[5:0];
        row      = d[10:6];
        val      = d[14:11];
        mode     = d[16:15];
        in_range = (col < PANEL_WIDTH) && (row < PANEL_HEIGHT);
        idx      = int'(col) * (PANEL_HEIGHT / 2) + int'(row[4:1]);
        merge    = row[0] ? {val, 4'b0} : {4'b0, val};
        case (act)
            ACT_WRITE: begin
                if (in_range) begin
                    case (mode)
                        OVL_OR:   frame_mem[idx] = frame_mem[idx] | merge;
                        OVL_NAND: frame_mem[idx] = frame_mem[idx] & ~merge;
                        OVL_XOR:  frame_mem[idx] = frame_mem[idx] ^ merge;
                        default: ;
                    endcase
                end
            end
            ACT_READ: begin
                nib = 4'd0;
                if (in_range) begin
                    nib = row[0] ? frame_mem[idx][7:4] : frame_mem[idx][3:0];
                end
                queue_word(KIND_PIXEL, {4'b0, nib}, 1'b1);
            end
            ACT_TICK: predict_tick();
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                frame_mem[i] = 8'd0;
            end
            scan_row = 3'd0;
            duty     = 4'd0;
            expected_words.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_word(i_in_user, i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                got_word.kind = i_out_kind;
                got_word.data = i_out_data;
                got_word.last = i_out_last;
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected output word: kind %0d byte %02h last %0d",
                                 got_word.kind, got_word.data, got_word.last);
                    end
                end else begin
                    want_word = expected_words.pop_front();
                    checked++;
                    if (got_word !== want_word) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
                                     want_word.kind, want_word.data, want_word.last,
                                     got_word.kind, got_word.data, got_word.last);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
        o_checked    <= checked;
    end

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lmps_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [1:0] OVL_KEEP  = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_data = 24'd0;  // col[5:0], row_sel[10:6], pixel_value[14:11], overlay_mode[16:15]
    logic [1:0]  s_user = 2'd0;   // action[1:0]
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data;          // out_byte[7:0]
    logic [0:0]  m_user;          // kind[0]
    logic        m_last;

    int fail_count;
    int pending;
    int checked;
    int n_write = 0;
    int n_read = 0;
    int n_tick = 0;
    int n_ignored = 0;
    int n_sent = 0;
    int stall_left = 0;
    int rx_cycles = 0;

    always #2 i_clk = ~i_clk;

    led_matrix_pwm_scan dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    led_matrix_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_in_user    (s_user),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_out_kind   (m_user[0]),
        .i_out_last   (m_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side stalls, with a calm stretch, where no new stall starts, in every fourth window
    always @(posedge i_clk) begin
        rx_cycles <= rx_cycles + 1;
        if (!i_rst_n) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (((rx_cycles / 256) % 4) != 3 && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [1:0] act, input logic [5:0] col,
                             input logic [4:0] row, input logic [3:0] val,
                             input logic [1:0] mode);
        int gap;
        gap = ((n_sent % 64) < 16) ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'b0, mode, val, row, col};
        s_user  <= act;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        n_sent++;
        if (act == ACT_WRITE && col < PANEL_WIDTH && row < PANEL_HEIGHT) n_write++;
        else if (act == ACT_READ) n_read++;
        else if (act == ACT_TICK) n_tick++;
        else n_ignored++;
    endtask

    function automatic logic [5:0] any_col();
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [4:0] any_row();
        return 5'($urandom_range(0, 31));
    endfunction

    initial begin
        int r;
        int n_rand;
        int k;
        n_rand = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: cleared store, two panel corners, each merge mode, out of range, unused action
        send_word(ACT_READ, 6'd0, 5'd0, 4'd0, OVL_OR);
        send_word(ACT_TICK, 6'd0, 5'd0, 4'd0, OVL_OR);
        send_word(ACT_WRITE, 6'd0, 5'd0, 4'hF, OVL_OR);
        send_word(ACT_WRITE, 6'd23, 5'd15, 4'hF, OVL_OR);
        send_word(ACT_WRITE, 6'd23, 5'd14, 4'hA, OVL_XOR);
        send_word(ACT_WRITE, 6'd6, 5'd0, 4'hF, OVL_OR);
        send_word(ACT_WRITE, 6'd6, 5'd9, 4'h5, OVL_OR);
        send_word(ACT_WRITE, 6'd14, 5'd3, 4'hE, OVL_OR);
        send_word(ACT_WRITE, 6'd0, 5'd0, 4'h5, OVL_NAND);
        send_word(ACT_WRITE, 6'd0, 5'd0, 4'hF, OVL_KEEP);
        send_word(ACT_WRITE, 6'd0, 5'd1, 4'h0, OVL_KEEP);
        send_word(ACT_WRITE, 6'd24, 5'd0, 4'hF, OVL_OR);
        send_word(ACT_WRITE, 6'd63, 5'd31, 4'hF, OVL_XOR);
        send_word(ACT_WRITE, 6'd0, 5'd16, 4'hF, OVL_OR);
        send_word(ACT_READ, 6'd0, 5'd0, 4'd0, OVL_OR);
        send_word(ACT_READ, 6'd23, 5'd15, 4'd0, OVL_OR);
        send_word(ACT_READ, 6'd23, 5'd14, 4'd0, OVL_OR);
        send_word(ACT_READ, 6'd63, 5'd31, 4'hF, OVL_KEEP);
        send_word(ACT_READ, 6'd24, 5'd0, 4'd0, OVL_OR);
        send_word(ACT_READ, 6'd0, 5'd16, 4'd0, OVL_OR);
        send_word(ACT_SPARE, 6'd63, 5'd31, 4'hF, OVL_KEEP);
        send_word(ACT_TICK, 6'd63, 5'd31, 4'hF, OVL_KEEP);
        send_word(ACT_TICK, 6'd0, 5'd0, 4'd0, OVL_OR);

        // random: mostly in-range traffic with enough ticks to wrap the duty cycle
        while (n_rand < 220 || n_tick < 80) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_word(ACT_WRITE, 6'($urandom_range(0, 23)), 5'($urandom_range(0, 15)),
                          4'($urandom), 2'($urandom));
                n_rand++;
            end else if (r < 58) begin
                send_word(ACT_READ, 6'($urandom_range(0, 23)), 5'($urandom_range(0, 15)),
                          4'($urandom), 2'($urandom));
                n_rand++;
            end else if (r < 93) begin
                send_word(ACT_TICK, any_col(), any_row(), 4'($urandom), 2'($urandom));
                n_rand++;
            end else begin
                k = $urandom_range(0, 2);
                if (k == 0) begin
                    send_word(ACT_SPARE, any_col(), any_row(), 4'($urandom), 2'($urandom));
                end else begin
                    send_word((k == 1) ? ACT_WRITE : ACT_READ, 6'($urandom_range(24, 63)),
                              any_row(), 4'($urandom), 2'($urandom));
                end
            end
        end
        s_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("sent %0d words: %0d writes, %0d reads, %0d scan ticks, %0d ignored or off-panel",
                 n_sent, n_write, n_read, n_tick, n_ignored);
        $display("compared %0d output words, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d output words still expected", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
